// File: hw/rtl/iwola_pkg.sv
package iwola_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 10;
   localparam int COEF_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int FLOOR_W  = 20;
   localparam int FOLD_W   = 36;
   localparam int ENV_W    = 34;
   localparam int FC_W     = 16;
   localparam int QUO_W    = 16;

   localparam int FFT_SIZE_DEF = 640;
   localparam int HOP_DEF      = 160;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_SAMPLE = 2'd1;
   localparam cmd_type CMD_DRAIN  = 2'd2;

   localparam logic [FOLD_W-1:0] FOLD_MAX = {1'b0, {(FOLD_W-1){1'b1}}};
   localparam logic [FOLD_W-1:0] FOLD_MIN = {1'b1, {(FOLD_W-1){1'b0}}};
   localparam logic [ENV_W-1:0]  ENV_MAX  = {ENV_W{1'b1}};
   localparam logic [FC_W-1:0]   FC_MAX   = {FC_W{1'b1}};

   localparam logic [SAMPLE_W-1:0] AUDIO_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] AUDIO_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// File: hw/rtl/iwola_req_if.sv
interface iwola_req_if import iwola_pkg::*; ();
   logic                       valid;
   logic                       ready;
   cmd_type                    command;
   logic [IDX_W-1:0]           window_index;
   logic [COEF_W-1:0]          coefficient;
   logic signed [SAMPLE_W-1:0] frame_sample;

   modport source (output valid, command, window_index, coefficient, frame_sample,
                   input ready);
   modport sink (input valid, command, window_index, coefficient, frame_sample,
                 output ready);
endinterface

// File: hw/rtl/iwola_rsp_if.sv
interface iwola_rsp_if import iwola_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_sample;
   logic                       envelope_error;
   logic                       last;

   modport source (output valid, audio_sample, envelope_error, last, input ready);
   modport sink (input valid, audio_sample, envelope_error, last, output ready);
endinterface

// File: hw/rtl/iwola_ram.sv
module iwola_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/istft_weighted_overlap_add_core.sv
// channel   port      dir  carries
// -------   --------  ---  ------------------------------------------------------
// request   req_chan  in   command, window_index, coefficient, frame_sample
// response  rsp_chan  out  audio_sample, envelope_error, last
// csr       csr_*     in   envelope_floor, written whenever csr_we is high
//
// one beat in flight at a time. loads and ignored beats stay in idle; a sample
// or drain goes via read and write, one with a result then via setup, the 16
// radix-2 quotient divider steps and done, skipping to done on quotient overflow
// or an envelope error. reset is synchronous; the rings need no clearing pass,
// the first frame of a stream reads them as zero. a waiting result sits in the
// output register and only holds the block back once the next result is ready.
module istft_weighted_overlap_add_core import iwola_pkg::*; #(
   parameter int FFT_SIZE = FFT_SIZE_DEF,
   parameter int HOP      = HOP_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [FLOOR_W-1:0] csr_wdata,
   iwola_req_if.sink          req_chan,
   iwola_rsp_if.source        rsp_chan
);

   localparam int AW      = $clog2(FFT_SIZE);
   localparam int HALF    = FFT_SIZE / 2;
   localparam int HOP_MOD = HOP % FFT_SIZE;
   localparam int QW      = FC_W + $clog2(HOP + 1) + 2;
   localparam int DCW     = $clog2(QUO_W);
   localparam int PRODW   = SAMPLE_W + COEF_W + 1;
   localparam int SQW     = 2 * COEF_W;
   localparam int NW      = FOLD_W + QUO_W + 1;
   localparam int DW      = ENV_W + 1;

   localparam logic [AW:0]       FFT_L     = (AW+1)'(FFT_SIZE);
   localparam logic [AW:0]       BACK_L    = (AW+1)'(FFT_SIZE - HOP_MOD);
   localparam logic [AW:0]       HOP_L     = (AW+1)'(HOP_MOD);
   localparam logic [AW-1:0]     POS_LAST  = AW'(FFT_SIZE - 1);
   localparam logic [AW-1:0]     DRN_LAST  = AW'(HALF - 1);
   localparam logic [QW-1:0]     SMP_LIMIT = QW'(FFT_SIZE + HALF);
   localparam logic [QW-1:0]     DRN_LIMIT = QW'(HALF + HOP);
   localparam logic [QUO_W-1:0]  POS_LIM   = QUO_W'(AUDIO_MAX);
   localparam logic [QUO_W-1:0]  NEG_LIM   = QUO_W'(AUDIO_MIN);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WRITE,
      S_SETUP,
      S_DIV,
      S_DONE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   logic [FC_W-1:0]    fc_ff, fc_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      drain_ff, drain_in;
   logic [AW-1:0]      base_ff, base_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-beat working registers
   logic                       is_sample_ff, is_sample_in;
   logic [AW-1:0]              slot_ff, slot_in;
   logic                       first_ff, first_in;
   logic                       ovw_ff, ovw_in;
   logic                       emit_ff, emit_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [PRODW-1:0]    prod_ff, prod_in;
   logic [SQW-1:0]             sq_ff, sq_in;
   logic [FOLD_W-1:0]          fold_old_ff, fold_old_in;
   logic [ENV_W-1:0]           env_old_ff, env_old_in;
   logic                       neg_ff, neg_in;
   logic                       err_ff, err_in;
   logic [FOLD_W-1:0]          mag_ff, mag_in;
   logic [DW-1:0]              rem_ff, rem_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic                       ovf_ff, ovf_in;
   logic [DCW-1:0]             cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]        audio_ff, audio_in;
   logic                       err_out_ff, err_out_in;
   logic                       last_out_ff, last_out_in;

   // memory ports
   logic              win_we, win_re;
   logic [AW-1:0]     win_waddr;
   logic [COEF_W-1:0] win_rd;
   logic              ring_we, ring_re;
   logic [AW-1:0]     ring_raddr;
   logic [FOLD_W-1:0] fold_wr, fold_rd;
   logic [ENV_W-1:0]  env_wr, env_rd;

   // datapath helpers
   logic              accept;
   logic              smp_ok, drn_ok, load_ok;
   logic [QW-1:0]     fch;
   logic [AW:0]       slot_smp_w, slot_lb_w, slot_drn_w;
   logic [AW-1:0]     slot_smp, slot_lb, slot_drn;
   logic              ovw_now, smp_emit, drn_emit;
   logic [FOLD_W:0]   fold_sum;
   logic [ENV_W:0]    env_sum;
   logic [FOLD_W-1:0] fold_base;
   logic [ENV_W-1:0]  env_base;
   logic [NW-1:0]     num;
   logic [DW-1:0]     div_d;
   logic [DW:0]       div_t;
   logic              div_ge;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign smp_ok  = (drain_ff == '0);
   assign drn_ok  = (fc_ff != '0) && (pos_ff == '0);
   assign load_ok = ({1'b0, req_chan.window_index} < (IDX_W+1)'(FFT_SIZE));

   assign fch = QW'(fc_ff) * QW'(HOP);

   always_comb begin
      slot_smp_w = {1'b0, base_ff} + {1'b0, pos_ff};
      if (slot_smp_w >= FFT_L) begin
         slot_smp_w = slot_smp_w - FFT_L;
      end
      slot_smp = slot_smp_w[AW-1:0];

      // the last frame started one hop behind the ring base
      slot_lb_w = {1'b0, base_ff} + BACK_L;
      if (slot_lb_w >= FFT_L) begin
         slot_lb_w = slot_lb_w - FFT_L;
      end
      slot_lb = slot_lb_w[AW-1:0];

      slot_drn_w = {1'b0, slot_lb} + {1'b0, drain_ff};
      if (slot_drn_w >= FFT_L) begin
         slot_drn_w = slot_drn_w - FFT_L;
      end
      slot_drn = slot_drn_w[AW-1:0];
   end

   assign ovw_now  = (QW'(pos_ff) + QW'(HOP)) >= QW'(FFT_SIZE);
   assign smp_emit = ovw_now && ((fch + QW'(pos_ff)) >= SMP_LIMIT);
   assign drn_emit = (fch + QW'(drain_ff)) >= DRN_LIMIT;

   // window table
   assign win_we    = accept && (req_chan.command == CMD_LOAD) && load_ok;
   assign win_waddr = req_chan.window_index[AW-1:0];
   assign win_re    = accept && (req_chan.command == CMD_SAMPLE) && smp_ok;

   iwola_ram #(
      .WIDTH (COEF_W),
      .DEPTH (FFT_SIZE)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (req_chan.coefficient),
      .rd_en   (win_re),
      .rd_addr (pos_ff),
      .rd_data (win_rd)
   );

   // rings
   assign ring_re = accept && (((req_chan.command == CMD_SAMPLE) && smp_ok) ||
                               ((req_chan.command == CMD_DRAIN) && drn_ok));
   assign ring_raddr = (req_chan.command == CMD_SAMPLE) ? slot_smp : slot_drn;
   assign ring_we = (state_ff == S_WRITE) && is_sample_ff;

   // new territory and the first frame of a stream start from zero
   assign fold_base = (ovw_ff || first_ff) ? '0 : fold_old_ff;
   assign env_base  = (ovw_ff || first_ff) ? '0 : env_old_ff;
   assign fold_sum  = {fold_base[FOLD_W-1], fold_base} + (FOLD_W+1)'(prod_ff);
   assign env_sum   = {1'b0, env_base} + (ENV_W+1)'(sq_ff);

   always_comb begin
      if (fold_sum[FOLD_W] != fold_sum[FOLD_W-1]) begin
         fold_wr = fold_sum[FOLD_W] ? FOLD_MIN : FOLD_MAX;
      end else begin
         fold_wr = fold_sum[FOLD_W-1:0];
      end
      env_wr = env_sum[ENV_W] ? ENV_MAX : env_sum[ENV_W-1:0];
   end

   iwola_ram #(
      .WIDTH (FOLD_W),
      .DEPTH (FFT_SIZE)
   ) u_fold_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (slot_ff),
      .wr_data (fold_wr),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (fold_rd)
   );

   iwola_ram #(
      .WIDTH (ENV_W),
      .DEPTH (FFT_SIZE)
   ) u_env_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (slot_ff),
      .wr_data (env_wr),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (env_rd)
   );

   // divider: q = floor(N / D), N = mag*2^16 + env, D = 2*env
   assign num    = {1'b0, mag_ff, {QUO_W{1'b0}}} + NW'(env_old_ff);
   assign div_d  = {env_old_ff, 1'b0};
   assign div_t  = {rem_ff, quo_ff[QUO_W-1]};
   assign div_ge = div_t >= {1'b0, div_d};

   always_comb begin
      state_in     = state_ff;
      floor_in     = csr_we ? csr_wdata : floor_ff;
      fc_in        = fc_ff;
      pos_in       = pos_ff;
      drain_in     = drain_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      is_sample_in = is_sample_ff;
      slot_in      = slot_ff;
      first_in     = first_ff;
      ovw_in       = ovw_ff;
      emit_in      = emit_ff;
      last_in      = last_ff;
      sample_in    = sample_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      fold_old_in  = fold_old_ff;
      env_old_in   = env_old_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      audio_in     = audio_ff;
      err_out_in   = err_out_ff;
      last_out_in  = last_out_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in = req_chan.frame_sample;
               first_in  = (fc_ff == '0);
               if ((req_chan.command == CMD_SAMPLE) && smp_ok) begin
                  is_sample_in = 1'b1;
                  slot_in      = slot_smp;
                  ovw_in       = ovw_now;
                  emit_in      = smp_emit;
                  last_in      = 1'b0;
                  state_in     = S_READ;
                  if (pos_ff == POS_LAST) begin
                     pos_in = '0;
                     if (fc_ff != FC_MAX) begin
                        fc_in = fc_ff + 1'b1;
                     end
                     if (({1'b0, base_ff} + HOP_L) >= FFT_L) begin
                        base_in = AW'({1'b0, base_ff} + HOP_L - FFT_L);
                     end else begin
                        base_in = AW'({1'b0, base_ff} + HOP_L);
                     end
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end else if ((req_chan.command == CMD_DRAIN) && drn_ok) begin
                  is_sample_in = 1'b0;
                  slot_in      = slot_drn;
                  ovw_in       = 1'b0;
                  emit_in      = drn_emit;
                  last_in      = (drain_ff == DRN_LAST);
                  state_in     = S_READ;
                  if (drain_ff == DRN_LAST) begin
                     // end of stream: back to a fresh start
                     fc_in    = '0;
                     pos_in   = '0;
                     drain_in = '0;
                     base_in  = '0;
                  end else begin
                     drain_in = drain_ff + 1'b1;
                  end
               end
            end
         end

         S_READ: begin
            prod_in     = sample_ff * $signed({1'b0, win_rd});
            sq_in       = win_rd * win_rd;
            fold_old_in = fold_rd;
            env_old_in  = env_rd;
            state_in    = S_WRITE;
         end

         S_WRITE: begin
            err_in = (env_old_ff <= ENV_W'(floor_ff));
            neg_in = fold_old_ff[FOLD_W-1];
            mag_in = fold_old_ff[FOLD_W-1] ? (~fold_old_ff + 1'b1) : fold_old_ff;
            if (!emit_ff) begin
               state_in = S_IDLE;
            end else if (env_old_ff <= ENV_W'(floor_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SETUP;
            end
         end

         S_SETUP: begin
            ovf_in = num >= NW'({div_d, {QUO_W{1'b0}}});
            rem_in = num[QUO_W +: DW];
            quo_in = num[QUO_W-1:0];
            cnt_in = {DCW{1'b1}};
            state_in = (num >= NW'({div_d, {QUO_W{1'b0}}})) ? S_DONE : S_DIV;
         end

         S_DIV: begin
            rem_in = div_ge ? DW'(div_t - {1'b0, div_d}) : div_t[DW-1:0];
            quo_in = {quo_ff[QUO_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               err_out_in   = err_ff;
               last_out_in  = last_ff;
               if (err_ff) begin
                  audio_in = '0;
               end else if (neg_ff) begin
                  audio_in = (ovf_ff || (quo_ff > NEG_LIM)) ? AUDIO_MIN :
                                                               SAMPLE_W'(~quo_ff + 1'b1);
               end else begin
                  audio_in = (ovf_ff || (quo_ff > POS_LIM)) ? AUDIO_MAX :
                                                               SAMPLE_W'(quo_ff);
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         floor_ff     <= '0;
         fc_ff        <= '0;
         pos_ff       <= '0;
         drain_ff     <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         fc_ff        <= fc_in;
         pos_ff       <= pos_in;
         drain_ff     <= drain_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_sample_ff <= is_sample_in;
      slot_ff      <= slot_in;
      first_ff     <= first_in;
      ovw_ff       <= ovw_in;
      emit_ff      <= emit_in;
      last_ff      <= last_in;
      sample_ff    <= sample_in;
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      fold_old_ff  <= fold_old_in;
      env_old_ff   <= env_old_in;
      neg_ff       <= neg_in;
      err_ff       <= err_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      ovf_ff       <= ovf_in;
      cnt_ff       <= cnt_in;
      audio_ff     <= audio_in;
      err_out_ff   <= err_out_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.audio_sample   = $signed(audio_ff);
   assign rsp_chan.envelope_error = err_out_ff;
   assign rsp_chan.last           = last_out_ff;

endmodule
